>>> design/u2e_pkg.sv
// types, constants and codes for the utf-8 to euc-jp font selector
// used by u2e_scan and utf8_to_euc_font_select; no dependencies
package u2e_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int TBL_AW      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = TBL_AW + 1;

	localparam int CFG_W       = 13;
	localparam int IN_DATA_W   = 80;
	localparam int OUT_DATA_W  = 56;

	localparam logic [CFG_W-1:0] ENTRY_COUNT_RST = 13'd2965;

	localparam logic [7:0]  ASCII_LIMIT = 8'h7F;
	localparam logic [7:0]  MB_LEAD    = 8'hE3;
	localparam logic [23:0] HIRA_OFS   = 24'hE2DCE0;
	localparam logic [23:0] HIRA_OFS2  = 24'hE2DDA0;
	localparam logic [23:0] HIRA_SPLIT = 24'hE381BF;
	localparam logic [23:0] HIRA_END   = 24'hE38293;
	localparam logic [23:0] KATA_OFS   = 24'hE2DD00;
	localparam logic [23:0] KATA_OFS2  = 24'hE2DDC0;
	localparam logic [23:0] KATA_SPLIT = 24'hE382BF;
	localparam logic [23:0] KATA_END   = 24'hE383B6;

	localparam logic [15:0] ASCII_BASE = 16'd32;
	localparam logic [15:0] HIRA_BASE  = 16'hA4A1;
	localparam logic [15:0] KATA_BASE  = 16'hA5A1;
	localparam logic [15:0] KANJI_BASE = 16'hB0A1;
	localparam logic [15:0] KANJI_ROW0 = 16'h00B0;
	localparam logic [15:0] ROW_SPAN   = 16'h00A2;
	localparam logic [15:0] CODE_NONE  = 16'hFFFF;

	typedef enum logic [1:0] {
		STS_OK          = 2'd0,
		STS_NOT_FOUND   = 2'd1,
		STS_UNSUPPORTED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		BANK_ASCII = 2'd0,
		BANK_HIRA  = 2'd1,
		BANK_KATA  = 2'd2,
		BANK_KANJI = 2'd3
	} bank_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_PUSH
	} fsm_t;

	typedef struct packed {
		logic [1:0]  consumed;
		status_t     status;
		logic [15:0] code;
		bank_t       bank;
		logic [15:0] base;
	} res_t;

	// request from the top level to the table search unit
	typedef struct packed {
		logic             start;
		logic [23:0]      key;
		logic [CNT_W-1:0] limit;
		logic             wr_en;
		logic [11:0]      wr_idx;
		logic [23:0]      wr_utf;
		logic [15:0]      wr_euc;
	} scan_req_t;

	typedef struct packed {
		logic        done;
		logic        found;
		logic [15:0] euc;
	} scan_rsp_t;

	// font base of a kanji row: 0xb0a1 + (row - 0xb0) * 0xa2, mod 2^16
	function automatic logic [15:0] kanji_base(input logic [7:0] row);
		logic [15:0] diff;
		logic [31:0] prod;
		diff = {8'd0, row} - KANJI_ROW0;
		prod = 32'(diff) * 32'(ROW_SPAN);
		return KANJI_BASE + prod[15:0];
	endfunction

endpackage

>>> design/u2e_scan.sv
// kanji table memory and first-match linear search, one entry per cycle
// depends on u2e_pkg
module u2e_scan
	import u2e_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  scan_req_t req,
	output scan_rsp_t rsp
);

	logic [39:0]      mem [TABLE_DEPTH];
	logic [39:0]      rd_data_s1;
	logic             rd_vld_s1;
	logic             busy_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] limit_q;
	logic [23:0]      key_q;
	logic             issue;
	logic             hit;
	logic             done;
	logic             wr_ok;

	assign wr_ok = req.wr_en && (32'(req.wr_idx) < TABLE_DEPTH);
	assign issue = busy_q && (idx_q < limit_q);
	assign hit   = busy_q && rd_vld_s1 && (rd_data_s1[39:16] == key_q);
	assign done  = busy_q && (hit || (idx_q == limit_q));

	// entry layout: utf in the upper 24 bits, euc in the lower 16
	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[TBL_AW'(req.wr_idx)] <= {req.wr_utf, req.wr_euc};
		end
		if (issue) begin
			rd_data_s1 <= mem[idx_q[TBL_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
			idx_q     <= '0;
			limit_q   <= '0;
			key_q     <= '0;
		end else begin
			rd_vld_s1 <= issue && !done;
			if (req.start) begin
				busy_q  <= 1'b1;
				idx_q   <= '0;
				limit_q <= req.limit;
				key_q   <= req.key;
			end else begin
				if (done) begin
					busy_q <= 1'b0;
				end
				if (issue) begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	assign rsp.done  = done;
	assign rsp.found = hit;
	assign rsp.euc   = rd_data_s1[15:0];

endmodule

>>> design/utf8_to_euc_font_select.sv
// utf-8 to euc-jp converter with font bank selection; uses u2e_pkg and u2e_scan
// ascii, hiragana, katakana and unsupported beats are decoded into the output register,
// or the pending register while it is full; a kanji beat scans the table one entry per
// cycle to the first match or through limit entries, limit = min(entry_count, table depth)
// throughput: one beat at a time; a kanji beat holds the input until its search ends;
// a result stalled behind a full output register holds the input until it is taken
module utf8_to_euc_font_select
	import u2e_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// lead_byte[7:0], second_byte[15:8], third_byte[23:16], entry_index[35:24],
	// entry_utf[59:36], entry_euc[75:60], zero[79:76]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// kind[0]: 0 load table entry, 1 convert character
	input  logic                  s_axis_tuser,
	// result stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// consumed_bytes[1:0], status[3:2], char_code[19:4], font_bank[21:20],
	// font_base[37:22], glyph_index[53:38], zero[55:54]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// entry_count register write
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_W-1:0]      cfg_data
);

	fsm_t             state_q, state_d;
	logic [CFG_W-1:0] entry_count_q;

	// remembered character state
	logic [15:0]      last_code_q;
	bank_t            last_bank_q;
	logic [15:0]      last_base_q;

	// output register and one pending result behind it
	logic             out_vld_q;
	res_t             out_q;
	res_t             pend_q;

	// input beat fields
	logic             in_beat;
	logic             kind;
	logic [7:0]       lead_byte;
	logic [7:0]       second_byte;
	logic [7:0]       third_byte;
	logic [11:0]      entry_index;
	logic [23:0]      entry_utf;
	logic [15:0]      entry_euc;
	logic [23:0]      utf;

	logic             out_free;
	logic             fast_done;
	logic             scan_start;
	res_t             fast_res;
	res_t             res;
	logic             res_vld;
	logic             load_out;
	logic             load_pend;
	logic [CNT_W-1:0] limit;

	scan_req_t        scan_req;
	scan_rsp_t        scan_rsp;

	assign lead_byte   = s_axis_tdata[7:0];
	assign second_byte = s_axis_tdata[15:8];
	assign third_byte  = s_axis_tdata[23:16];
	assign entry_index = s_axis_tdata[35:24];
	assign entry_utf   = s_axis_tdata[59:36];
	assign entry_euc   = s_axis_tdata[75:60];
	assign kind        = s_axis_tuser;
	assign utf         = {lead_byte, second_byte, third_byte};

	assign s_axis_tready = (state_q == FSM_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign out_free      = !out_vld_q || m_axis_tready;

	// search limit saturates at the table depth
	assign limit = (32'(entry_count_q) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
		: CNT_W'(entry_count_q);

	// decode of a convert beat: results that need no table search, else the start of a search
	always_comb begin
		fast_res   = '{consumed: 2'd0, status: STS_UNSUPPORTED, code: last_code_q,
			bank: last_bank_q, base: last_base_q};
		fast_done  = 1'b0;
		scan_start = 1'b0;
		if (in_beat && kind) begin
			if (lead_byte >= MB_LEAD) begin
				fast_res.consumed = 2'd3;
				fast_res.status   = STS_OK;
				if (utf <= HIRA_END) begin
					// hiragana block, split around the gap in the middle byte
					fast_res.code = (utf <= HIRA_SPLIT) ? 16'(utf - HIRA_OFS)
						: 16'(utf - HIRA_OFS2);
					fast_res.bank = BANK_HIRA;
					fast_res.base = HIRA_BASE;
					fast_done     = 1'b1;
				end else if (utf <= KATA_END) begin
					fast_res.code = (utf <= KATA_SPLIT) ? 16'(utf - KATA_OFS)
						: 16'(utf - KATA_OFS2);
					fast_res.bank = BANK_KATA;
					fast_res.base = KATA_BASE;
					fast_done     = 1'b1;
				end else begin
					// everything else goes through the kanji table
					scan_start = 1'b1;
				end
			end else if (lead_byte < ASCII_LIMIT) begin
				fast_res.consumed = 2'd1;
				fast_res.status   = STS_OK;
				fast_res.code     = {8'd0, lead_byte};
				fast_res.bank     = BANK_ASCII;
				fast_res.base     = ASCII_BASE;
				fast_done         = 1'b1;
			end else begin
				// unsupported lead byte: remembered values go out unchanged
				fast_done = 1'b1;
			end
		end
	end

	// result of a finished search or of a fast decode
	always_comb begin
		res     = fast_res;
		res_vld = fast_done;
		if (state_q == FSM_SCAN && scan_rsp.done) begin
			res_vld = 1'b1;
			if (scan_rsp.found) begin
				res = '{consumed: 2'd3, status: STS_OK, code: scan_rsp.euc,
					bank: BANK_KANJI, base: kanji_base(scan_rsp.euc[15:8])};
			end else begin
				// a miss keeps the previous bank and base
				res = '{consumed: 2'd3, status: STS_NOT_FOUND, code: CODE_NONE,
					bank: last_bank_q, base: last_base_q};
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		load_out  = 1'b0;
		load_pend = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				if (scan_start) begin
					state_d = FSM_SCAN;
				end else if (res_vld) begin
					if (out_free) begin
						load_out = 1'b1;
					end else begin
						load_pend = 1'b1;
						state_d   = FSM_PUSH;
					end
				end
			end
			FSM_SCAN: begin
				if (res_vld) begin
					if (out_free) begin
						load_out = 1'b1;
						state_d  = FSM_IDLE;
					end else begin
						load_pend = 1'b1;
						state_d   = FSM_PUSH;
					end
				end
			end
			FSM_PUSH: begin
				if (out_free) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= FSM_IDLE;
			entry_count_q <= ENTRY_COUNT_RST;
			last_code_q   <= '0;
			last_bank_q   <= BANK_ASCII;
			last_base_q   <= '0;
			out_vld_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				entry_count_q <= cfg_data;
			end
			if (res_vld) begin
				last_code_q <= res.code;
				last_bank_q <= res.bank;
				last_base_q <= res.base;
			end
			if (load_out || (state_q == FSM_PUSH && out_free)) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= res;
		end else if (state_q == FSM_PUSH && out_free) begin
			out_q <= pend_q;
		end
		if (load_pend) begin
			pend_q <= res;
		end
	end

	assign scan_req = '{start: scan_start, key: utf, limit: limit,
		wr_en: in_beat && !kind, wr_idx: entry_index, wr_utf: entry_utf,
		wr_euc: entry_euc};

	u2e_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (scan_req),
		.rsp    (scan_rsp)
	);

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {2'b00, out_q.code - out_q.base, out_q.base,
		out_q.bank, out_q.code, out_q.status, out_q.consumed};

endmodule
